[rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, command and result codes for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KIND_W  = 3;

  // in word: now_ms, timeout_ms, request_id, slot, zero pad
  localparam int unsigned S_TDATA_W = 88;
  // out word: handle, owner, wait_ms, queue_empty, zero pad
  localparam int unsigned M_TDATA_W = 56;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADDED      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_ACTIVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WAIT       = 3'd6;

  typedef struct packed {
    logic              carry;
    logic [TIME_W-1:0] sum;
  } dtq_alu_res_t;

endpackage

[rtl/dtq_ram.sv]
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dtq_alu.sv]
// ----------------------------------------------------------------------------
// dtq_alu
// Shared 32-bit add/subtract unit with carry out, used for deadline sums,
// deadline compares and wait computation.
// ----------------------------------------------------------------------------
module dtq_alu (
  input  logic [dtq_pkg::TIME_W-1:0] a_i,
  input  logic [dtq_pkg::TIME_W-1:0] b_i,
  input  logic                       sub_i,
  output dtq_pkg::dtq_alu_res_t      res_o
);
  import dtq_pkg::*;

  logic [TIME_W:0] total;

  // on subtract, carry set means a >= b
  assign total = {1'b0, a_i} + {1'b0, b_i ^ {TIME_W{sub_i}}} + {{TIME_W{1'b0}}, sub_i};

  assign res_o.carry = total[TIME_W];
  assign res_o.sum   = total[TIME_W-1:0];

endmodule

[rtl/deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Add searches the slots for a free one, cancel acts directly, query scans
// every slot, and an expire check rescans all slots after each expired timer;
// one word per item, k words for a burst of k expired timers, one item at a time.
// Each scan reads one slot per cycle through the shared compare unit.
// Reset clears the active flags and control state; deadline and owner stores stay undefined.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
  parameter int unsigned DEPTH = dtq_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms[31:0], timeout_ms[63:32], request_id[79:64], slot[85:80], zero[87:86]
  input  logic [dtq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // cmd[1:0]
  input  logic [dtq_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // handle[5:0], owner[21:6], wait_ms[53:22], queue_empty[54], zero[55]
  output logic [dtq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // kind[2:0]
  output logic [dtq_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import dtq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_CANCEL = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEPTH-1:0] active_q, active_d;

  logic [CMD_W-1:0]   cmd_q;
  logic [TIME_W-1:0]  now_q, tmo_q;
  logic [OWNER_W-1:0] rid_q;
  logic [SLOT_W-1:0]  slot_q;

  logic p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;

  logic best_vld_q, best_vld_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_dl_q, best_dl_d;
  logic [OWNER_W-1:0] best_own_q, best_own_d;

  logic hold_vld_q, hold_vld_d;
  logic [IDX_W-1:0] hold_idx_q, hold_idx_d;
  logic [OWNER_W-1:0] hold_own_q, hold_own_d;

  logic out_vld_q, out_vld_d;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [SLOT_W-1:0] out_handle_q, out_handle_d;
  logic [OWNER_W-1:0] out_owner_q, out_owner_d;
  logic [TIME_W-1:0] out_wait_q, out_wait_d;
  logic out_empty_q, out_empty_d;
  logic out_last_q, out_last_d;

  logic in_acc, can_emit, emit, at_end, in_range, due;
  logic [IDX_W-1:0] idx, sidx;

  logic [TIME_W-1:0]  alu_a, alu_b;
  logic               alu_sub;
  dtq_alu_res_t       alu_res;
  logic               ram_we;
  logic [TIME_W-1:0]  dl_rdata, dl_wdata;
  logic [OWNER_W-1:0] own_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign can_emit = !out_vld_q || m_axis_tready;
  assign idx      = cnt_q[IDX_W-1:0];
  assign sidx     = slot_q[IDX_W-1:0];
  assign at_end   = (cnt_q == CNT_W'(DEPTH));
  assign in_range = ({1'b0, slot_q} < (SLOT_W + 1)'(DEPTH));
  assign due      = best_vld_q && alu_res.carry;
  assign dl_wdata = alu_res.carry ? {TIME_W{1'b1}} : alu_res.sum;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = now_q;
    alu_b   = tmo_q;
    alu_sub = 1'b0;
    case (state_q)
      ST_SCAN: begin
        alu_a   = dl_rdata;
        alu_b   = best_dl_q;
        alu_sub = 1'b1;
      end
      ST_DECIDE: begin
        alu_sub = 1'b1;
        if (cmd_q == CMD_EXPIRE) begin
          alu_a = now_q;
          alu_b = best_dl_q;
        end else begin
          alu_a = best_dl_q;
          alu_b = now_q;
        end
      end
      default: begin
        alu_a   = now_q;
        alu_b   = tmo_q;
        alu_sub = 1'b0;
      end
    endcase
  end

  dtq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  dtq_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (dl_wdata),
    .raddr_i (idx),
    .rdata_o (dl_rdata)
  );

  dtq_ram #(.WIDTH(OWNER_W), .DEPTH(DEPTH)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (rid_q),
    .raddr_i (idx),
    .rdata_o (own_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    active_d     = active_q;
    p_vld_d      = 1'b0;
    p_idx_d      = p_idx_q;
    best_vld_d   = best_vld_q;
    best_idx_d   = best_idx_q;
    best_dl_d    = best_dl_q;
    best_own_d   = best_own_q;
    hold_vld_d   = hold_vld_q;
    hold_idx_d   = hold_idx_q;
    hold_own_d   = hold_own_q;
    ram_we       = 1'b0;
    emit         = 1'b0;
    out_kind_d   = out_kind_q;
    out_handle_d = '0;
    out_owner_d  = '0;
    out_wait_d   = '0;
    out_empty_d  = 1'b0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d      = '0;
          best_vld_d = 1'b0;
          hold_vld_d = 1'b0;
          case (s_axis_tuser)
            CMD_ADD:    state_d = ST_ADD;
            CMD_CANCEL: state_d = ST_CANCEL;
            default:    state_d = ST_SCAN;
          endcase
        end
      end

      ST_ADD: begin
        if (!at_end && active_q[idx]) begin
          cnt_d = cnt_q + 1'b1;
        end else if (can_emit) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (at_end) begin
            out_kind_d = KIND_FULL;
          end else begin
            ram_we        = 1'b1;
            active_d[idx] = 1'b1;
            out_kind_d    = KIND_ADDED;
            out_handle_d  = SLOT_W'(idx);
          end
        end
      end

      ST_CANCEL: begin
        if (can_emit) begin
          emit         = 1'b1;
          state_d      = ST_IDLE;
          out_handle_d = slot_q;
          if (in_range && active_q[sidx]) begin
            active_d[sidx] = 1'b0;
            out_kind_d     = KIND_CANCELLED;
          end else begin
            out_kind_d = KIND_NOT_ACTIVE;
          end
        end
      end

      ST_SCAN: begin
        // read data arrives in the cycle after the address
        if (p_vld_q && (!best_vld_q || !alu_res.carry)) begin
          best_vld_d = 1'b1;
          best_idx_d = p_idx_q;
          best_dl_d  = dl_rdata;
          best_own_d = own_rdata;
        end
        if (at_end) begin
          state_d = ST_DECIDE;
        end else begin
          p_vld_d = active_q[idx];
          p_idx_d = idx;
          cnt_d   = cnt_q + 1'b1;
        end
      end

      ST_DECIDE: begin
        if (cmd_q == CMD_EXPIRE) begin
          if (due) begin
            // the held timer is not the last one, so it can go out now
            if (!hold_vld_q || can_emit) begin
              if (hold_vld_q) begin
                emit         = 1'b1;
                out_kind_d   = KIND_EXPIRED;
                out_handle_d = SLOT_W'(hold_idx_q);
                out_owner_d  = hold_own_q;
                out_last_d   = 1'b0;
              end
              hold_vld_d           = 1'b1;
              hold_idx_d           = best_idx_q;
              hold_own_d           = best_own_q;
              active_d[best_idx_q] = 1'b0;
              cnt_d                = '0;
              best_vld_d           = 1'b0;
              state_d              = ST_SCAN;
            end
          end else if (can_emit) begin
            emit       = 1'b1;
            state_d    = ST_IDLE;
            hold_vld_d = 1'b0;
            if (hold_vld_q) begin
              out_kind_d   = KIND_EXPIRED;
              out_handle_d = SLOT_W'(hold_idx_q);
              out_owner_d  = hold_own_q;
            end else begin
              out_kind_d = KIND_NONE_DUE;
            end
          end
        end else if (can_emit) begin
          emit        = 1'b1;
          state_d     = ST_IDLE;
          out_kind_d  = KIND_WAIT;
          out_empty_d = !best_vld_q;
          if (best_vld_q && alu_res.carry) begin
            out_wait_d = alu_res.sum;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      active_q   <= '0;
      p_vld_q    <= 1'b0;
      best_vld_q <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      active_q   <= active_d;
      p_vld_q    <= p_vld_d;
      best_vld_q <= best_vld_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= s_axis_tuser;
      now_q  <= s_axis_tdata[31:0];
      tmo_q  <= s_axis_tdata[63:32];
      rid_q  <= s_axis_tdata[79:64];
      slot_q <= s_axis_tdata[85:80];
    end
    p_idx_q    <= p_idx_d;
    best_idx_q <= best_idx_d;
    best_dl_q  <= best_dl_d;
    best_own_q <= best_own_d;
    hold_idx_q <= hold_idx_d;
    hold_own_q <= hold_own_d;
    if (emit) begin
      out_kind_q   <= out_kind_d;
      out_handle_q <= out_handle_d;
      out_owner_q  <= out_owner_d;
      out_wait_q   <= out_wait_d;
      out_empty_q  <= out_empty_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_empty_q, out_wait_q, out_owner_q, out_handle_q};

endmodule

[rtl/dtq_checker.sv]
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks for the deadline timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dtq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [dtq_pkg::KIND_W-1:0]    m_axis_tuser,
  input logic                          m_axis_tlast
);
  import dtq_pkg::*;

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // only expire bursts carry more than one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_EXPIRED) |-> m_axis_tlast)
    else $error("single result without last");

  // empty flag only on a wait answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[54] |-> (m_axis_tuser == KIND_WAIT))
    else $error("queue_empty on wrong kind");

  // an empty queue reports zero wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[54] |-> (m_axis_tdata[53:22] == '0))
    else $error("nonzero wait on empty queue");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
